@@ rtl/led_matrix_row_scanner_assert.svh @@
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_assert.svh
// Assertion macros shared by the row scanner modules.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ROW_SCANNER_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every edge out of reset
`define LRS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("row scanner assertion failed");

// ante implies cons in the same cycle
`define LRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row scanner assertion failed");

// ante implies cons in the next cycle
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row scanner assertion failed");

`else

`define LRS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define LRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/lrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrs_pkg
// Types and constants shared by the row scanner controller and datapath.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int ROW_W = 16;   // stored row word width
    localparam int PTR_W = 4;    // scan pointer width
    localparam int EN_W  = 10;   // row driver count
    localparam int PAT_W = 8;    // fill byte width
    localparam int SHA_W = 5;    // signed shift amount width
    localparam int OP_W  = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_SHIFT = 2'd2;
    localparam logic [OP_W-1:0] OP_SCAN  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic op_accept;    // item taken: apply buffer op or start scan
        logic search_step;  // current row empty, advance search index
        logic load_row;     // found row: load column shift register
        logic emit_clock;   // issue one column clock item
        logic emit_latch;   // issue latch item, update active row
        logic emit_done;    // issue frame done item, wrap pointer
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic search_over;  // search index past the last row
        logic row_found;    // row at search index is non-empty
        logic last_col;     // column counter on the final column
        logic out_free;     // output register can take an item
    } t_sts;

endpackage

@@ rtl/lrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrs_ctrl
// Sequencer for the row scanner: accept, row search, column shift, latch or frame done.
// ----------------------------------------------------------------------------
`include "led_matrix_row_scanner_assert.svh"

module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_operation,
    input  t_sts            i_sts,
    output t_cmd            o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_LATCH  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;
    logic       w_emit;
    logic [3:0] w_step_bits;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.op_accept = 1'b1;
                    if (i_operation == OP_SCAN) begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (i_sts.search_over) begin
                    n_state = ST_DONE;
                end else if (i_sts.row_found) begin
                    o_cmd.load_row = 1'b1;
                    n_state        = ST_SHIFT;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_clock = 1'b1;
                    if (i_sts.last_col) begin
                        n_state = ST_LATCH;
                    end
                end
            end
            ST_LATCH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_latch = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_emit      = o_cmd.emit_clock || o_cmd.emit_latch || o_cmd.emit_done;
    assign w_step_bits = {o_cmd.search_step, o_cmd.load_row, w_emit, o_cmd.op_accept};

    // never overwrite an item still waiting at the output
    `LRS_ASSERT_IMP(a_emit_needs_room, i_clk, i_rst_n, w_emit, i_sts.out_free)
    // at most one datapath action per cycle
    `LRS_ASSERT_ALWAYS(a_one_action, i_clk, i_rst_n, $onehot0(w_step_bits))
    // last item of a scan returns control to idle
    `LRS_ASSERT_NEXT(a_latch_to_idle, i_clk, i_rst_n, o_cmd.emit_latch, r_state == ST_IDLE)

endmodule

@@ rtl/lrs_datapath.sv @@
// ----------------------------------------------------------------------------
// lrs_datapath
// Frame buffer, scan pointer, column shift register and output register.
// ----------------------------------------------------------------------------
`include "led_matrix_row_scanner_assert.svh"

module lrs_datapath
    import lrs_pkg::*;
#(
    parameter int ROW_COUNT    = 10,
    parameter int COLUMN_COUNT = 12
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [PTR_W-1:0]        i_row_index,
    input  logic [ROW_W-1:0]        i_row_data,
    input  logic [PAT_W-1:0]        i_fill_pattern,
    input  logic signed [SHA_W-1:0] i_shift_amount,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_serial_data,
    output logic                    o_shift_clock,
    output logic                    o_latch_strobe,
    output logic [EN_W-1:0]         o_row_enable,
    output logic                    o_frame_done,
    output logic                    o_last
);

    localparam int IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMN_COUNT - 1);
    localparam logic [PTR_W:0]   ROW_LIMIT = (PTR_W + 1)'(ROW_COUNT);
    localparam logic [PTR_W:0]   EN_LIMIT  = (PTR_W + 1)'(EN_W);

    logic [ROW_W-1:0] r_rows [ROW_COUNT];
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W:0]   r_search;       // one extra bit so it can pass the last row
    logic [EN_W-1:0]  r_active;
    logic [ROW_W-1:0] r_shreg;
    logic [COL_W-1:0] r_col;

    logic             r_out_valid;
    logic             r_out_serial;
    logic             r_out_clk;
    logic             r_out_latch;
    logic [EN_W-1:0]  r_out_en;
    logic             r_out_done;
    logic             r_out_last;

    logic             w_in_range;
    logic [ROW_W-1:0] w_row;
    logic             w_write_ok;
    logic [SHA_W-1:0] w_mag;
    logic [EN_W-1:0]  w_onehot;
    logic             w_emit;

    // search read
    assign w_in_range = (r_search < ROW_LIMIT);
    assign w_row      = w_in_range ? r_rows[r_search[IDX_W-1:0]] : '0;

    assign w_write_ok = ({1'b0, i_row_index} < ROW_LIMIT);
    assign w_mag      = SHA_W'(~i_shift_amount + SHA_W'(1));
    assign w_onehot   = (r_search < EN_LIMIT) ?
                        (EN_W'(1) << r_search[PTR_W-1:0]) : '0;
    assign w_emit     = i_cmd.emit_clock || i_cmd.emit_latch || i_cmd.emit_done;

    assign o_sts.search_over = !w_in_range;
    assign o_sts.row_found   = w_in_range && (w_row != '0);
    assign o_sts.last_col    = (r_col == LAST_COL);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // frame buffer: whole-row ops work on every row in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_rows[i] <= '0;
            end
        end else if (i_cmd.op_accept) begin
            unique case (i_operation)
                OP_WRITE: begin
                    if (w_write_ok) begin
                        r_rows[i_row_index[IDX_W-1:0]] <= i_row_data;
                    end
                end
                OP_FILL: begin
                    for (int i = 0; i < ROW_COUNT; i++) begin
                        r_rows[i] <= {i_fill_pattern, i_fill_pattern};
                    end
                end
                OP_SHIFT: begin
                    for (int i = 0; i < ROW_COUNT; i++) begin
                        if (i_shift_amount[SHA_W-1]) begin
                            r_rows[i] <= r_rows[i] >> w_mag;
                        end else begin
                            r_rows[i] <= r_rows[i] << i_shift_amount[SHA_W-2:0];
                        end
                    end
                end
                OP_SCAN: begin
                end
                default: begin
                end
            endcase
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_active <= '0;
            r_search <= '0;
        end else begin
            if (i_cmd.op_accept && (i_operation == OP_SCAN)) begin
                r_search <= {1'b0, r_ptr};
            end else if (i_cmd.search_step) begin
                r_search <= r_search + 1'b1;
            end
            if (i_cmd.emit_latch) begin
                r_active <= w_onehot;
                r_ptr    <= r_search[PTR_W-1:0] + 1'b1;
            end else if (i_cmd.emit_done) begin
                r_ptr <= '0;
            end
        end
    end

    // column shift register, LSB goes out first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row) begin
            r_shreg <= w_row;
            r_col   <= '0;
        end else if (i_cmd.emit_clock) begin
            r_shreg <= r_shreg >> 1;
            r_col   <= r_col + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_clock) begin
            r_out_serial <= ~r_shreg[0];
            r_out_clk    <= 1'b1;
            r_out_latch  <= 1'b0;
            r_out_en     <= r_active;
            r_out_done   <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (i_cmd.emit_latch) begin
            r_out_serial <= 1'b0;
            r_out_clk    <= 1'b0;
            r_out_latch  <= 1'b1;
            r_out_en     <= w_onehot;
            r_out_done   <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_done) begin
            r_out_serial <= 1'b0;
            r_out_clk    <= 1'b0;
            r_out_latch  <= 1'b0;
            r_out_en     <= r_active;
            r_out_done   <= 1'b1;
            r_out_last   <= 1'b1;
        end else begin
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_serial_data  = r_out_serial;
    assign o_shift_clock  = r_out_clk;
    assign o_latch_strobe = r_out_latch;
    assign o_row_enable   = r_out_en;
    assign o_frame_done   = r_out_done;
    assign o_last         = r_out_last;

    `LRS_ASSERT_ALWAYS(a_active_onehot, i_clk, i_rst_n, $onehot0(r_active))
    // column clocks never close an item
    `LRS_ASSERT_IMP(a_clock_not_last, i_clk, i_rst_n, r_out_valid && r_out_clk, !r_out_last)
    // frame done wraps the pointer and flags the output
    `LRS_ASSERT_NEXT(a_done_wraps, i_clk, i_rst_n, i_cmd.emit_done, (r_ptr == '0) && r_out_done)

endmodule

@@ rtl/led_matrix_row_scanner.sv @@
// ----------------------------------------------------------------------------
// led_matrix_row_scanner
// Write row, fill and shift complete in the accept cycle; ready again the next cycle.
// Scan tick: accept, a search up from the pointer, then COLUMN_COUNT clock
// items and one latch item; an item waits while the output stalls.
// No row left: accept, a search past the last row, then one frame done item.
// Reset (i_rst_n low, synchronous) clears the buffer, pointer and active row.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner
    import lrs_pkg::*;
#(
    parameter int ROW_COUNT    = 10,
    parameter int COLUMN_COUNT = 12
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input item channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [PTR_W-1:0]        i_row_index,
    input  logic [ROW_W-1:0]        i_row_data,
    input  logic [PAT_W-1:0]        i_fill_pattern,
    input  logic signed [SHA_W-1:0] i_shift_amount,
    // result item channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_serial_data,
    output logic                    o_shift_clock,
    output logic                    o_latch_strobe,
    output logic [EN_W-1:0]         o_row_enable,
    output logic                    o_frame_done,
    output logic                    o_last
);

    // The controller only sequences; all storage lives in the datapath.
    // Buffer ops complete in the accept cycle. A scan walks the search
    // index up from the pointer until it hits a non-empty row or runs off
    // the end, then streams columns through the output register, which
    // lets the sequencer keep working while an item waits downstream.

    t_cmd w_cmd;
    t_sts w_sts;

    lrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lrs_datapath #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_operation    (i_operation),
        .i_row_index    (i_row_index),
        .i_row_data     (i_row_data),
        .i_fill_pattern (i_fill_pattern),
        .i_shift_amount (i_shift_amount),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_serial_data  (o_serial_data),
        .o_shift_clock  (o_shift_clock),
        .o_latch_strobe (o_latch_strobe),
        .o_row_enable   (o_row_enable),
        .o_frame_done   (o_frame_done),
        .o_last         (o_last)
    );

endmodule
